>>> rtl/cgs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cgs_pkg
// Shared constants for the cylindrical gradient shader: register indexes,
// reset values, arctangent table and divide-by-1000 reciprocal.
// ----------------------------------------------------------------------------
package cgs_pkg;

    localparam int CORDIC_STEPS_DEF = 16;
    localparam int ANGLE_BITS_DEF   = 16;
    localparam int ATAN_LEN         = 24;

    // x and z grow by the cordic gain, 36 bits keeps the sign clear
    localparam int CORDIC_W = 36;

    // configuration register indexes
    localparam logic [1:0] REG_CYCLE_COUNT  = 2'd0;
    localparam logic [1:0] REG_SWIRL_ENABLE = 2'd1;
    localparam logic [1:0] REG_NEAR_COLOR   = 2'd2;
    localparam logic [1:0] REG_FAR_COLOR    = 2'd3;

    localparam logic [15:0] CYCLE_COUNT_RST = 16'd256;
    localparam logic        SWIRL_RST       = 1'b0;
    localparam logic [23:0] NEAR_COLOR_RST  = 24'hFFFFFF;
    localparam logic [23:0] FAR_COLOR_RST   = 24'h000000;

    // turn fractions of atan(2^-i), Q0.32
    localparam logic [31:0] ATAN_TURNS [0:ATAN_LEN-1] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C,
        32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
        32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051
    };

    // digit divider: floor(v / 1000) = (v * DIV_MUL) >> DIV_SHIFT for v < 2^18
    localparam int          DIV_W      = 18;
    localparam int          DIV_MUL_W  = 19;
    localparam int          DIV_SHIFT  = 28;
    localparam logic [18:0] DIV_MUL    = 19'd268436;
    localparam logic [17:0] DIV_BASE   = 18'd1000;
    localparam int          DIV_UNITS  = 5;
    localparam int          SWIRL_LAT  = 2 * DIV_UNITS;
    // multiple of 1000 that lifts the integer part of y above zero
    localparam logic [17:0] SWIRL_OFFSET = 18'd33000;

endpackage

>>> rtl/cgs_swirl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cgs_swirl
// Fraction of y/1000 as a Q0.32 turn value, by a chain of radix-256
// divide-by-1000 digit units, two register stages per unit.
// ----------------------------------------------------------------------------
module cgs_swirl
    import cgs_pkg::*;
(
    input  logic               clk,
    input  logic               en,
    input  logic signed [31:0] y_coord,
    output logic        [31:0] swirl_frac
);

    logic [DIV_W-1:0] v_reg    [0:DIV_UNITS-1];
    logic [7:0]       q_reg    [0:DIV_UNITS-1];
    logic [9:0]       rem_reg  [0:DIV_UNITS-1];
    logic [15:0]      fa_reg   [0:DIV_UNITS-1];
    logic [15:0]      fb_reg   [0:DIV_UNITS-1];
    logic [31:0]      acca_reg [0:DIV_UNITS-1];
    logic [31:0]      accb_reg [0:DIV_UNITS-1];

    genvar k;
    generate
        for (k = 0; k < DIV_UNITS; k++) begin : g_unit
            logic [DIV_W-1:0]           v_next;
            logic [15:0]                f_next;
            logic [31:0]                acc_next;
            logic [DIV_W+DIV_MUL_W-1:0] prod;
            logic [7:0]                 q_next;
            logic [DIV_W-1:0]           q_times;
            logic [DIV_W-1:0]           diff;

            if (k == 0) begin : g_first
                // unit zero reduces the integer part of y modulo 1000
                assign v_next   = {{2{y_coord[31]}}, y_coord[31:16]} + SWIRL_OFFSET;
                assign f_next   = y_coord[15:0];
                assign acc_next = '0;
            end
            else begin : g_digit
                logic [7:0] byte_in;
                if (k == 1) begin : g_hi
                    assign byte_in = fb_reg[k-1][15:8];
                end
                else if (k == 2) begin : g_lo
                    assign byte_in = fb_reg[k-1][7:0];
                end
                else begin : g_zero
                    assign byte_in = 8'h00;
                end
                assign v_next   = {rem_reg[k-1], byte_in};
                assign f_next   = fb_reg[k-1];
                assign acc_next = accb_reg[k-1];
            end

            assign prod    = (DIV_W + DIV_MUL_W)'(v_next) * (DIV_W + DIV_MUL_W)'(DIV_MUL);
            assign q_next  = prod[DIV_SHIFT +: 8];
            assign q_times = DIV_W'(q_reg[k]) * DIV_BASE;
            assign diff    = v_reg[k] - q_times;

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    v_reg[k]    <= v_next;
                    q_reg[k]    <= q_next;
                    fa_reg[k]   <= f_next;
                    acca_reg[k] <= acc_next;
                    rem_reg[k]  <= diff[9:0];
                    fb_reg[k]   <= fa_reg[k];
                    if (k == 0)
                    begin
                        accb_reg[k] <= '0;
                    end
                    else
                    begin
                        accb_reg[k] <= {acca_reg[k][23:0], q_reg[k]};
                    end
                end
            end
        end
    endgenerate

    assign swirl_frac = accb_reg[DIV_UNITS-1];

endmodule

>>> rtl/cgs_cordic.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cgs_cordic
// Pipelined vectoring cordic: turn fraction of atan2(z, x), one iteration
// per stage, rounded to ANGLE_BITS bits.
// ----------------------------------------------------------------------------
module cgs_cordic
    import cgs_pkg::*;
#(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF,
    parameter int ANGLE_BITS   = ANGLE_BITS_DEF
)
(
    input  logic               clk,
    input  logic               en,
    input  logic signed [31:0] x_coord,
    input  logic signed [31:0] z_coord,
    output logic        [31:0] angle
);

    localparam int          LOW_BITS  = 32 - ANGLE_BITS;
    localparam logic [31:0] HALF      = 32'h1 << (LOW_BITS - 1);
    localparam logic [31:0] KEEP_MASK = ~((32'h1 << LOW_BITS) - 32'h1);

    logic signed [CORDIC_W-1:0] x_reg    [0:CORDIC_STEPS];
    logic signed [CORDIC_W-1:0] z_reg    [0:CORDIC_STEPS];
    logic        [31:0]         ph_reg   [0:CORDIC_STEPS];
    logic                       zero_reg [0:CORDIC_STEPS];
    logic        [31:0]         angle_reg;

    logic signed [CORDIC_W-1:0] x_ext;
    logic signed [CORDIC_W-1:0] z_ext;
    logic        [31:0]         ph_sum;

    assign x_ext = CORDIC_W'(x_coord);
    assign z_ext = CORDIC_W'(z_coord);

    // left half plane is folded over by a half turn
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            zero_reg[0] <= (x_coord == 32'sd0) && (z_coord == 32'sd0);
            if (x_coord < 0)
            begin
                x_reg[0]  <= -x_ext;
                z_reg[0]  <= -z_ext;
                ph_reg[0] <= 32'h80000000;
            end
            else
            begin
                x_reg[0]  <= x_ext;
                z_reg[0]  <= z_ext;
                ph_reg[0] <= 32'h0;
            end
        end
    end

    genvar i;
    generate
        for (i = 0; i < CORDIC_STEPS; i++) begin : g_iter
            logic signed [CORDIC_W-1:0] dx;
            logic signed [CORDIC_W-1:0] dz;

            assign dx = z_reg[i] >>> i;
            assign dz = x_reg[i] >>> i;

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    zero_reg[i+1] <= zero_reg[i];
                    if (z_reg[i] > 0)
                    begin
                        x_reg[i+1]  <= x_reg[i] + dx;
                        z_reg[i+1]  <= z_reg[i] - dz;
                        ph_reg[i+1] <= ph_reg[i] + ATAN_TURNS[i];
                    end
                    else
                    begin
                        x_reg[i+1]  <= x_reg[i] - dx;
                        z_reg[i+1]  <= z_reg[i] + dz;
                        ph_reg[i+1] <= ph_reg[i] - ATAN_TURNS[i];
                    end
                end
            end
        end
    endgenerate

    assign ph_sum = ph_reg[CORDIC_STEPS] + HALF;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            angle_reg <= zero_reg[CORDIC_STEPS] ? 32'h0 : (ph_sum & KEEP_MASK);
        end
    end

    assign angle = angle_reg;

endmodule

>>> rtl/cylindrical_gradient_shader.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cylindrical_gradient_shader
// Cylindrical angular gradient: angle about y, optional swirl, cycle count,
// up/down ramp and per-channel blend of two colors.
// ----------------------------------------------------------------------------
// One point is taken every cycle unless the pipeline holds; its color passes
// through one fold stage, one stage per cordic iteration, the rounding stage,
// then swirl add, cycle multiply, ramp select, blend multiply and the output
// register. The swirl divider runs beside the cordic. While a finished
// color waits on the output with m_axis_tready low, the whole pipeline holds
// in place; with no color waiting it keeps moving.
module cylindrical_gradient_shader
    import cgs_pkg::*;
#(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF,
    parameter int ANGLE_BITS   = ANGLE_BITS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [95:0] s_axis_tdata,   // x_coord, y_coord, z_coord
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // ramp_value, red, green, blue, zero pad
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [23:0] cfg_data
);

    localparam int ANG_LAT = CORDIC_STEPS + 2;
    localparam int Y_DLY   = ANG_LAT - SWIRL_LAT;
    localparam int LAT     = ANG_LAT + 5;

    logic [15:0] cycle_count_reg;
    logic        swirl_enable_reg;
    logic [23:0] near_color_reg;
    logic [23:0] far_color_reg;

    logic [LAT-1:0] vld_reg;
    logic [LAT-1:0] vld_next;
    logic           en;

    logic signed [31:0] x_in;
    logic signed [31:0] y_in;
    logic signed [31:0] z_in;
    logic signed [31:0] y_sw;
    logic        [31:0] angle;
    logic        [31:0] swirl_frac;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cycle_count_reg  <= CYCLE_COUNT_RST;
            swirl_enable_reg <= SWIRL_RST;
            near_color_reg   <= NEAR_COLOR_RST;
            far_color_reg    <= FAR_COLOR_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_CYCLE_COUNT:  cycle_count_reg  <= cfg_data[15:0];
                REG_SWIRL_ENABLE: swirl_enable_reg <= cfg_data[0];
                REG_NEAR_COLOR:   near_color_reg   <= cfg_data;
                REG_FAR_COLOR:    far_color_reg    <= cfg_data;
            endcase
        end
    end

    // valid bits, whole pipe advances unless the output is held
    assign en            = !vld_reg[LAT-1] || m_axis_tready;
    assign s_axis_tready = en;
    assign vld_next      = {vld_reg[LAT-2:0], s_axis_tvalid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= vld_next;
        end
    end

    assign x_in = s_axis_tdata[31:0];
    assign y_in = s_axis_tdata[63:32];
    assign z_in = s_axis_tdata[95:64];

    cgs_cordic #(
        .CORDIC_STEPS (CORDIC_STEPS),
        .ANGLE_BITS   (ANGLE_BITS)
    ) u_cordic (
        .clk     (clk),
        .en      (en),
        .x_coord (x_in),
        .z_coord (z_in),
        .angle   (angle)
    );

    // y waits so the swirl result lines up with the angle
    generate
        if (Y_DLY > 0) begin : g_ydly
            logic signed [31:0] y_dly_reg [0:Y_DLY-1];
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    y_dly_reg[0] <= y_in;
                    for (int j = 1; j < Y_DLY; j++)
                    begin
                        y_dly_reg[j] <= y_dly_reg[j-1];
                    end
                end
            end
            assign y_sw = y_dly_reg[Y_DLY-1];
        end
        else begin : g_ydir
            assign y_sw = y_in;
        end
    endgenerate

    cgs_swirl u_swirl (
        .clk        (clk),
        .en         (en),
        .y_coord    (y_sw),
        .swirl_frac (swirl_frac)
    );

    // back end: swirl add, cycle multiply, ramp, blend multiply, output
    logic [31:0] frac_reg;
    logic [47:0] cyc_prod;
    logic        seg_odd_reg;
    logic [15:0] pos_reg;
    logic [16:0] ramp_c_reg;
    logic [16:0] ramp_d_reg;
    logic [16:0] ramp_out_reg;
    logic [7:0]  near_d_reg [0:2];
    logic signed [26:0] blend_prod_reg [0:2];
    logic [7:0]  chan_out_reg [0:2];

    assign cyc_prod = 48'(frac_reg) * 48'(cycle_count_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            frac_reg     <= angle + (swirl_enable_reg ? swirl_frac : 32'h0);
            seg_odd_reg  <= cyc_prod[40];
            pos_reg      <= cyc_prod[39:24];
            ramp_c_reg   <= seg_odd_reg ? (17'h10000 - {1'b0, pos_reg}) : {1'b0, pos_reg};
            ramp_d_reg   <= ramp_c_reg;
            ramp_out_reg <= ramp_d_reg;
        end
    end

    // channel = near + ((far - near) * t + 0.5) >> 16
    genvar c;
    generate
        for (c = 0; c < 3; c++) begin : g_chan
            localparam int SH = 16 - 8 * c;
            logic        [7:0]  near_ch;
            logic        [7:0]  far_ch;
            logic signed [8:0]  delta;
            logic signed [26:0] mult;
            logic signed [27:0] total;

            assign near_ch = near_color_reg[SH +: 8];
            assign far_ch  = far_color_reg[SH +: 8];
            assign delta   = $signed({1'b0, far_ch}) - $signed({1'b0, near_ch});
            assign mult    = 27'(delta) * 27'($signed({1'b0, ramp_c_reg}));
            assign total   = $signed({4'b0, near_d_reg[c], 16'h0}) + 28'(blend_prod_reg[c])
                             + 28'sd32768;

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    near_d_reg[c]     <= near_ch;
                    blend_prod_reg[c] <= mult;
                    chan_out_reg[c]   <= total[23:16];
                end
            end
        end
    endgenerate

    assign m_axis_tvalid = vld_reg[LAT-1];
    assign m_axis_tdata  = {7'b0, chan_out_reg[2], chan_out_reg[1], chan_out_reg[0],
                            ramp_out_reg};

    // ramp never passes one
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[16:0] <= 17'h10000))
        else $error("ramp value above one");

    // ramp at zero gives the near color exactly
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && (m_axis_tdata[16:0] == 17'h0)) |->
        (m_axis_tdata[40:17] == {near_color_reg[7:0], near_color_reg[15:8],
                                 near_color_reg[23:16]}))
        else $error("zero ramp does not give near color");

    // ramp at one gives the far color exactly
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && (m_axis_tdata[16:0] == 17'h10000)) |->
        (m_axis_tdata[40:17] == {far_color_reg[7:0], far_color_reg[15:8],
                                 far_color_reg[23:16]}))
        else $error("full ramp does not give far color");

endmodule

>>> bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the cylindrical gradient shader. Points are sent on
// the input stream and each accepted transaction is shaded by a predictor
// kept in step with the register settings. Results on the output stream are
// checked field by field in order. Random idling on both sides, one long
// receiver hold-off, and register changes only while the pipeline is empty.
// ----------------------------------------------------------------------------
module tb_top;
    import cgs_pkg::*;

    localparam int PIPE_DRAIN = 40;
    localparam int RUN_LIMIT  = 200000;
    localparam int LONG_HOLD  = 300;
    localparam int RAND_PHASES = 6;
    localparam int PHASE_POINTS = 80;

    typedef struct packed {
        logic [31:0] x_coord;
        logic [31:0] y_coord;
        logic [31:0] z_coord;
    } point_t;

    typedef struct packed {
        logic [16:0] ramp_value;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
    } shade_t;

    // atan(2^-i) as Q0.32 turn fractions
    localparam logic [31:0] ATAN_STEP [0:15] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C
    };

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [95:0] s_axis_tdata = '0;   // x_coord, y_coord, z_coord
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;       // ramp_value, red, green, blue, zero pad
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic [23:0] cfg_data = '0;

    // predictor copy of the registers
    logic [15:0] seg_count_q88 = CYCLE_COUNT_RST;
    logic        swirl_on = SWIRL_RST;
    logic [23:0] near_rgb = NEAR_COLOR_RST;
    logic [23:0] far_rgb = FAR_COLOR_RST;

    point_t point_queue[$];
    shade_t color_expect[$];
    point_t on_bus;
    int     points_issued = 0;
    int     points_taken = 0;
    int     src_idle_pct = 0;
    int     snk_idle_pct = 0;
    int     gap_left = 0;
    int     stall_left = 0;
    int     hold_left = 0;
    logic   hold_request = 1'b0;
    logic   hold_done = 1'b0;
    int     error_total = 0;
    int     tick_count = 0;

    cylindrical_gradient_shader dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // angle of (x, z) about the y axis, Q0.32 turns rounded to 16 bits
    function automatic logic [31:0] cordic_turns(longint signed px, longint signed pz);
        logic [31:0] phase;
        logic [15:0] rounded;
        longint signed dx;
        longint signed dz;
        int i;
        phase = 32'd0;
        if (px == 0 && pz == 0)
            return 32'd0;
        if (px < 0)
        begin
            px = -px;
            pz = -pz;
            phase = 32'h80000000;
        end
        for (i = 0; i < 16; i++)
        begin
            dx = pz >>> i;
            dz = px >>> i;
            if (pz > 0)
            begin
                px = px + dx;
                pz = pz - dz;
                phase = phase + ATAN_STEP[i];
            end
            else
            begin
                px = px - dx;
                pz = pz + dz;
                phase = phase - ATAN_STEP[i];
            end
        end
        phase = phase + 32'h00008000;
        rounded = phase[31:16];
        return {rounded, 16'd0};
    endfunction

    function automatic logic [7:0] channel_mix(logic [7:0] n, logic [7:0] f, logic [16:0] t);
        logic [31:0] v;
        v = (32'(n) * (32'd65536 - 32'(t)) + 32'(f) * 32'(t) + 32'd32768) >> 16;
        return v[7:0];
    endfunction

    function automatic shade_t shade_point(point_t p);
        shade_t s;
        logic [31:0] frac;
        logic [63:0] prod;
        logic [15:0] pos;
        longint signed yv;
        longint signed rem;
        frac = cordic_turns(longint'($signed(p.x_coord)), longint'($signed(p.z_coord)));
        if (swirl_on)
        begin
            yv = longint'($signed(p.y_coord));
            rem = yv % 64'sd65536000;
            if (rem < 0)
                rem = rem + 64'sd65536000;
            frac = frac + 32'((rem * 65536) / 1000);
        end
        prod = {32'd0, frac} * {48'd0, seg_count_q88};
        pos = prod[39:24];
        // odd segments run the ramp downward
        s.ramp_value = prod[40] ? 17'd65536 - {1'b0, pos} : {1'b0, pos};
        s.red   = channel_mix(near_rgb[23:16], far_rgb[23:16], s.ramp_value);
        s.green = channel_mix(near_rgb[15:8], far_rgb[15:8], s.ramp_value);
        s.blue  = channel_mix(near_rgb[7:0], far_rgb[7:0], s.ramp_value);
        return s;
    endfunction

    function automatic logic [31:0] pick_coord();
        case ($urandom_range(0, 7))
            0: return 32'h80000000;
            1: return 32'h7FFFFFFF;
            2: return 32'(int'($urandom_range(0, 131072)) - 65536);
            3: return 32'd0;
            default: return $urandom();
        endcase
    endfunction

    // heights near whole multiples of 1000.0 stress the swirl wrap
    function automatic logic [31:0] pick_height();
        longint signed k;
        if ($urandom_range(0, 3) == 0)
        begin
            k = longint'(int'($urandom_range(0, 64)) - 32);
            return 32'(k * 65536000 + longint'(int'($urandom_range(0, 2)) - 1));
        end
        return pick_coord();
    endfunction

    function automatic logic [23:0] pick_color();
        case ($urandom_range(0, 4))
            0: return 24'h000000;
            1: return 24'hFFFFFF;
            default: return 24'($urandom());
        endcase
    endfunction

    function automatic logic [15:0] pick_seg_count();
        case ($urandom_range(0, 6))
            0: return 16'd0;
            1: return 16'hFFFF;
            2: return 16'd256;
            3: return 16'd512;
            4: return 16'($urandom_range(1, 1024));
            default: return 16'($urandom());
        endcase
    endfunction

    task automatic queue_point(logic [31:0] x, logic [31:0] y, logic [31:0] z);
        point_queue.push_back('{x_coord: x, y_coord: y, z_coord: z});
        points_issued++;
    endtask

    task automatic write_reg(logic [1:0] idx, logic [23:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            REG_CYCLE_COUNT:  seg_count_q88 = val[15:0];
            REG_SWIRL_ENABLE: swirl_on = val[0];
            REG_NEAR_COLOR:   near_rgb = val;
            REG_FAR_COLOR:    far_rgb = val;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic load_setup(logic [15:0] cc, logic [23:0] sw, logic [23:0] nr,
                              logic [23:0] fr);
        write_reg(REG_CYCLE_COUNT, {8'd0, cc});
        write_reg(REG_SWIRL_ENABLE, sw);
        write_reg(REG_NEAR_COLOR, nr);
        write_reg(REG_FAR_COLOR, fr);
    endtask

    // wait until every point is taken and every color has come back
    task automatic drain_pipe();
        while (!(points_taken == points_issued && color_expect.size() == 0))
            @(posedge clk);
        repeat (PIPE_DRAIN) @(posedge clk);
    endtask

    task automatic check_field(string name, int want, int got);
        if (want != got)
        begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            error_total++;
        end
    endtask

    // point source
    always @(posedge clk)
    begin
        logic nxt_valid;
        if (rst_n)
        begin
            nxt_valid = s_axis_tvalid;
            if (s_axis_tvalid && s_axis_tready)
            begin
                color_expect.push_back(shade_point(on_bus));
                points_taken++;
                nxt_valid = 1'b0;
                if ($urandom_range(0, 99) < src_idle_pct)
                    gap_left = $urandom_range(1, 5);
            end
            if (!nxt_valid)
            begin
                if (gap_left > 0)
                    gap_left--;
                else if (point_queue.size() > 0)
                begin
                    on_bus = point_queue.pop_front();
                    s_axis_tdata <= {on_bus.z_coord, on_bus.y_coord, on_bus.x_coord};
                    nxt_valid = 1'b1;
                end
            end
            s_axis_tvalid <= nxt_valid;
        end
    end

    // color sink and checker
    always @(posedge clk)
    begin
        shade_t got;
        shade_t want;
        logic nxt_ready;
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.ramp_value = m_axis_tdata[16:0];
                got.red        = m_axis_tdata[24:17];
                got.green      = m_axis_tdata[32:25];
                got.blue       = m_axis_tdata[40:33];
                if (color_expect.size() == 0)
                begin
                    $error("color transaction with no point pending: ramp_value %0d",
                           got.ramp_value);
                    error_total++;
                end
                else
                begin
                    want = color_expect.pop_front();
                    check_field("ramp_value", want.ramp_value, got.ramp_value);
                    check_field("red", want.red, got.red);
                    check_field("green", want.green, got.green);
                    check_field("blue", want.blue, got.blue);
                end
            end
            if (hold_request && !hold_done)
            begin
                hold_left = LONG_HOLD;
                hold_done = 1'b1;
            end
            nxt_ready = 1'b1;
            if (hold_left > 0)
            begin
                hold_left--;
                nxt_ready = 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                nxt_ready = 1'b0;
            end
            else if ($urandom_range(0, 99) < snk_idle_pct)
            begin
                stall_left = $urandom_range(1, 5) - 1;
                nxt_ready = 1'b0;
            end
            m_axis_tready <= nxt_ready;
        end
    end

    always @(posedge clk)
    begin
        tick_count <= tick_count + 1;
        if (tick_count == RUN_LIMIT)
        begin
            $display("FAIL cylindrical_gradient_shader");
            $finish;
        end
    end

    initial
    begin
        int p;
        int n;
        int src_pct [0:RAND_PHASES-1];
        int snk_pct [0:RAND_PHASES-1];
        src_pct = '{20, 35, 10, 0, 30, 0};
        snk_pct = '{20, 10, 35, 0, 30, 0};
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        src_idle_pct = 20;
        snk_idle_pct = 20;

        // reset settings: origin, axes, corners of the coordinate range
        queue_point(32'd0, 32'd0, 32'd0);
        queue_point(32'h00010000, 32'd0, 32'd0);
        queue_point(32'hFFFF0000, 32'd0, 32'd0);
        queue_point(32'd0, 32'd0, 32'h00010000);
        queue_point(32'd0, 32'd0, 32'hFFFF0000);
        queue_point(32'h7FFFFFFF, 32'd0, 32'h7FFFFFFF);
        queue_point(32'h80000000, 32'd0, 32'h80000000);
        queue_point(32'h80000000, 32'd0, 32'h7FFFFFFF);
        queue_point(32'h7FFFFFFF, 32'd0, 32'h80000000);
        queue_point(32'd1, 32'd0, 32'hFFFFFFFF);
        queue_point(32'h80000000, 32'h7FFFFFFF, 32'd0);
        drain_pipe();

        // two segments with swirl: half turn lands on an odd segment boundary
        load_setup(16'd512, 24'h000001, 24'h123456, 24'hFEDCBA);
        queue_point(32'hFFFF0000, 32'd0, 32'd0);
        queue_point(32'd0, 32'h80000000, 32'd0);
        queue_point(32'd0, 32'h7FFFFFFF, 32'd0);
        queue_point(32'd0, 32'd65536000, 32'd0);
        queue_point(32'd0, 32'hFFFFFFFF, 32'd0);
        queue_point(32'd0, 32'hFC180000, 32'd0);
        drain_pipe();

        // zero segment count gives the near color everywhere
        load_setup(16'd0, 24'hFFFFFE, 24'hA5A5A5, 24'h5A5A5A);
        queue_point(32'h12345678, 32'd0, 32'h9ABCDEF0);
        queue_point(32'h80000000, 32'd0, 32'd0);
        drain_pipe();

        load_setup(16'hFFFF, 24'd0, 24'h000000, 24'hFFFFFF);
        queue_point(32'h7FFFFFFF, 32'hFFFFFFFF, 32'h80000000);
        queue_point(32'hFFFFFFFF, 32'd0, 32'd1);
        queue_point(32'h00012345, 32'd0, 32'h0007FFFF);
        drain_pipe();

        for (p = 0; p < RAND_PHASES; p++)
        begin
            load_setup(pick_seg_count(), 24'($urandom()), pick_color(), pick_color());
            src_idle_pct = src_pct[p];
            snk_idle_pct = snk_pct[p];
            for (n = 0; n < PHASE_POINTS; n++)
                queue_point(pick_coord(), pick_height(), pick_coord());
            // receiver holds off while points keep coming, so the pipe backs up
            if (p == 2)
                hold_request = 1'b1;
            drain_pipe();
        end

        if (error_total == 0)
            $display("PASS cylindrical_gradient_shader");
        else
            $display("FAIL cylindrical_gradient_shader");
        $finish;
    end

endmodule

>>> filelist.f
rtl/cgs_pkg.sv
rtl/cgs_swirl.sv
rtl/cgs_cordic.sv
rtl/cylindrical_gradient_shader.sv
bench/tb_top.sv
